// ===== rtl/core/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;
	localparam int NumJointsDefault  = 256;
	localparam int InfluencesDefault = 4;
	localparam int MaxInfluences     = 4;
	localparam int ElemsPerMatrix    = 16;

	typedef enum logic [1:0] {
		CMD_JOINT = 2'd0,
		CMD_MVP   = 2'd1,
		CMD_VERT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;       // capture vertex fields
		logic       clr_acc;    // clear blend accumulator of current element
		logic       blend;      // accumulate weight * joint element
		logic       blend_last; // round/saturate element into skin matrix
		logic       mv_clr;     // clear row accumulator
		logic       mv_mac;     // one multiply-accumulate for a row
		logic       mv_pass;    // 0: skin*bind, 1: mvp*local
		logic       mv_row_end; // round row into result vector
		logic [1:0] row;
		logic [1:0] col;
		logic [3:0] elem;
	} lbs_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		if (v > 80'sd2147483647) return 32'sh7fffffff;
		if (v < -80'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/linear_blend_skinning_transform.sv =====
`default_nettype none
// Linear blend skinning with four influences, Q16.16. Words with tuser 0 or 1
// write one joint or MVP element. A vertex word (tuser 2) reads 16 elements
// of each used joint from the joint store, one per cycle, then runs two
// 16-step matrix-vector passes on one shared 32x32 multiplier with a
// two-stage MAC. After the vertex word is accepted the block stays busy
// until its result loads the output register. The result word waits there
// until taken; the input is not held off meanwhile, but a following vertex
// stays busy in its last state until the register is free. tuser 3 words
// are dropped.
module linear_blend_skinning_transform
	import lbs_pkg::*;
#(
	parameter int NUM_JOINTS = NumJointsDefault,
	parameter int INFLUENCES = InfluencesDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: table_index[7:0], element_index[11:8], element_value[43:12],
	// pos_x[75:44], pos_y[107:76], pos_z[139:108], joint_ids[171:140],
	// weights[235:172], texcoord_in[267:236]
	input  wire logic [271:0] s_tdata,
	input  wire logic [1:0]   s_tuser, // cmd
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tdata: clip_x, clip_y, clip_z, clip_w, texcoord_out (low to high)
	output logic [159:0]      m_tdata
);
	logic     acc_c, busy, done, rd_en, mv_c;
	logic [11:0] rd_addr;
	lbs_cmd_t cmd;
	logic signed [31:0] cx, cy, cz, cw;
	logic [31:0] tc;

	assign s_tready = !busy;
	assign acc_c    = s_tvalid && s_tready;

	lbs_ctrl #(.NUM_JOINTS(NUM_JOINTS), .INFLUENCES(INFLUENCES)) u_ctrl (
		.clk, .arst_n,
		.start(acc_c && (s_tuser == CMD_VERT)),
		.joint_ids(s_tdata[171:140]), .weights(s_tdata[235:172]),
		.out_free(!m_tvalid || m_tready),
		.busy, .done, .rd_en, .rd_addr, .cmd
	);

	lbs_dp #(.NUM_JOINTS(NUM_JOINTS)) u_dp (
		.clk,
		.wr_joint(acc_c && (s_tuser == CMD_JOINT)),
		.wr_mvp(acc_c && (s_tuser == CMD_MVP)),
		.table_index(s_tdata[7:0]), .element_index(s_tdata[11:8]),
		.element_value(s_tdata[43:12]),
		.pos_x(s_tdata[75:44]), .pos_y(s_tdata[107:76]), .pos_z(s_tdata[139:108]),
		.weights(s_tdata[235:172]), .texcoord_in(s_tdata[267:236]),
		.rd_en, .rd_addr, .cmd,
		.clip_x(cx), .clip_y(cy), .clip_z(cz), .clip_w(cw), .texcoord_out(tc)
	);

	// output register: load on done, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (done) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) m_tdata <= {tc, cw, cz, cy, cx};
	end

	assign mv_c = cmd.mv_mac;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("accept while busy");
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid) else $error("result lost");
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		!(mv_c && rd_en)) else $error("blend and mac overlap");
endmodule
`default_nettype wire

// ===== rtl/core/lbs_ctrl.sv =====
`default_nettype none
module lbs_ctrl
	import lbs_pkg::*;
#(
	parameter int NUM_JOINTS = NumJointsDefault,
	parameter int INFLUENCES = InfluencesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] joint_ids,
	input  wire logic [63:0] weights,
	input  wire logic        out_free,
	output logic             busy,
	output logic             done,
	output logic             rd_en,
	output logic [11:0]      rd_addr,
	output lbs_cmd_t         cmd
);
	localparam int NInf = (INFLUENCES < MaxInfluences) ? INFLUENCES : MaxInfluences;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_BLEND = 6'b000010,
		S_WAIT  = 6'b000100,
		S_MV    = 6'b001000,
		S_DRAIN = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t     state_q;
	logic [3:0] elem_q;
	logic [2:0] inf_q;
	logic [3:0] mask_q;
	logic [7:0] ids_q [MaxInfluences];
	logic [3:0] mac_q;      // row*4+col
	logic       pass_q;
	logic       rd_v_s1;    // read data in rd_q is valid
	logic       rd_last_s1;
	logic       rd_first_s1;
	logic [3:0] rd_elem_s1;
	logic [1:0] rd_inf_s1;
	logic       mv_v_s1;
	logic [3:0] mv_idx_s1;
	logic       mv_pass_s1;
	logic       mv_pending_q;

	logic [3:0] use_c;
	logic [2:0] nxt_inf_c;
	logic       more_c;

	function automatic logic [2:0] first_c(input logic [3:0] m);
		logic [2:0] f;
		f = 3'd0;
		for (int k = MaxInfluences - 1; k >= 0; k--)
			if (m[k]) f = 3'(k);
		return f;
	endfunction

	always_comb begin
		for (int k = 0; k < MaxInfluences; k++)
			use_c[k] = (k < NInf) && (weights[16*k +: 16] != 16'd0) &&
				(32'(joint_ids[8*k +: 8]) < NUM_JOINTS);
	end

	// next used influence after inf_q
	always_comb begin
		nxt_inf_c = 3'd4;
		for (int k = MaxInfluences - 1; k >= 0; k--)
			if (k > int'(inf_q) && mask_q[k]) nxt_inf_c = 3'(k);
		more_c = (nxt_inf_c != 3'd4);
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_OUT) && out_free;
	assign rd_en   = (state_q == S_BLEND);
	assign rd_addr = {ids_q[inf_q[1:0]], elem_q};

	always_comb begin
		cmd            = '0;
		cmd.load       = start;
		cmd.clr_acc    = rd_v_s1 && rd_first_s1;
		cmd.blend      = rd_v_s1;
		cmd.blend_last = rd_v_s1 && rd_last_s1;
		cmd.elem       = rd_elem_s1;
		cmd.mv_mac     = mv_v_s1;
		cmd.mv_clr     = mv_v_s1 && (mv_idx_s1[1:0] == 2'd0);
		cmd.mv_row_end = mv_v_s1 && (mv_idx_s1[1:0] == 2'd3);
		cmd.mv_pass    = mv_v_s1 ? mv_pass_s1 : pass_q;
		cmd.row        = mv_idx_s1[3:2];
		cmd.col        = mv_idx_s1[1:0];
		if (rd_v_s1) begin
			cmd.row = 2'd0;
			cmd.col = rd_inf_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_v_s1 <= 1'b0;
			mv_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_BLEND);
			mv_v_s1 <= (state_q == S_MV);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mask_q <= use_c;
						for (int k = 0; k < MaxInfluences; k++)
							ids_q[k] <= joint_ids[8*k +: 8];
						elem_q <= '0;
						// move to first used influence
						inf_q  <= first_c(use_c);
						if (use_c == 4'd0) begin
							mac_q   <= '0;
							pass_q  <= 1'b0;
							state_q <= S_MV;
						end else begin
							state_q <= S_BLEND;
						end
					end
				end
				S_BLEND: begin
					rd_elem_s1  <= elem_q;
					rd_inf_s1   <= inf_q[1:0];
					rd_first_s1 <= (inf_q == first_c(mask_q));
					rd_last_s1  <= !more_c;
					if (more_c) inf_q <= nxt_inf_c;
					else begin
						inf_q <= first_c(mask_q);
						if (elem_q == 4'd15) state_q <= S_WAIT;
						else elem_q <= elem_q + 4'd1;
					end
				end
				S_WAIT: begin
					mac_q   <= '0;
					pass_q  <= 1'b0;
					state_q <= S_MV;
				end
				S_MV: begin
					mv_idx_s1  <= mac_q;
					mv_pass_s1 <= pass_q;
					mac_q      <= mac_q + 4'd1;
					if (mac_q == 4'd15) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!mv_v_s1 && !mv_pending_q) begin
						if (pass_q) state_q <= S_OUT;
						else begin
							pass_q  <= 1'b1;
							mac_q   <= '0;
							state_q <= S_MV;
						end
					end
				end
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// mirrors the MAC accumulate stage in the datapath so that S_DRAIN waits for it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mv_pending_q <= 1'b0;
		else mv_pending_q <= mv_v_s1;
	end
endmodule
`default_nettype wire

// ===== rtl/core/lbs_dp.sv =====
`default_nettype none
module lbs_dp
	import lbs_pkg::*;
#(
	parameter int NUM_JOINTS = NumJointsDefault
) (
	input  wire logic               clk,
	input  wire logic               wr_joint,
	input  wire logic               wr_mvp,
	input  wire logic [7:0]         table_index,
	input  wire logic [3:0]         element_index,
	input  wire logic signed [31:0] element_value,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic [63:0]        weights,
	input  wire logic [31:0]        texcoord_in,
	input  wire logic               rd_en,
	input  wire logic [11:0]        rd_addr,
	input  lbs_cmd_t                cmd,
	output logic signed [31:0]      clip_x,
	output logic signed [31:0]      clip_y,
	output logic signed [31:0]      clip_z,
	output logic signed [31:0]      clip_w,
	output logic [31:0]             texcoord_out
);
	localparam int Depth = NUM_JOINTS * ElemsPerMatrix;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

	logic [31:0]        joint_mem [Depth];
	logic signed [31:0] mvp_q  [16];
	logic signed [31:0] skin_q [16];
	logic signed [31:0] vec_q  [4];   // bind, then local
	logic signed [31:0] res_q  [4];
	logic [15:0]        wts_q  [MaxInfluences];
	logic signed [31:0] rd_q;
	logic signed [49:0] bacc_q;
	logic signed [63:0] prod_s2;
	logic [1:0]         prow_s2;
	logic               pend_s2, pclr_s2, pend_row_s2;
	logic               ppass_s2;
	logic signed [79:0] macc_q;

	always_ff @(posedge clk) begin
		if (wr_joint && (32'(table_index) < NUM_JOINTS))
			joint_mem[AW'({table_index, element_index})] <= element_value;
		if (rd_en) rd_q <= joint_mem[AW'(rd_addr)];
	end

	logic signed [49:0] bsum_c;
	logic signed [49:0] bround_c;
	logic signed [31:0] mul_a_c, mul_b_c;
	logic signed [79:0] msum_c, mround_c;

	always_comb begin
		bsum_c   = (cmd.clr_acc ? 50'sd0 : bacc_q) +
			50'($signed({1'b0, wts_q[cmd.col]}) * rd_q);
		bround_c = (bsum_c + 50'sd16384) >>> 15;
		mul_a_c  = cmd.mv_pass ? mvp_q[{cmd.row, cmd.col}] : skin_q[{cmd.row, cmd.col}];
		mul_b_c  = vec_q[cmd.col];
		msum_c   = (pclr_s2 ? 80'sd0 : macc_q) + 80'(prod_s2);
		mround_c = (msum_c + 80'sd32768) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (wr_mvp) mvp_q[element_index] <= element_value;
		if (cmd.load) begin
			vec_q[0] <= pos_x;
			vec_q[1] <= pos_y;
			vec_q[2] <= pos_z;
			vec_q[3] <= 32'sd65536;
			for (int k = 0; k < MaxInfluences; k++) wts_q[k] <= weights[16*k +: 16];
			for (int e = 0; e < 16; e++) skin_q[e] <= '0;
			texcoord_out <= texcoord_in;
		end
		if (cmd.blend) begin
			bacc_q <= bsum_c;
			if (cmd.blend_last) skin_q[cmd.elem] <= sat32(80'(bround_c));
		end
		// stage 1: multiply
		pend_s2 <= cmd.mv_mac;
		if (cmd.mv_mac) begin
			prod_s2     <= mul_a_c * mul_b_c;
			prow_s2     <= cmd.row;
			pclr_s2     <= cmd.mv_clr;
			pend_row_s2 <= cmd.mv_row_end;
			ppass_s2    <= cmd.mv_pass;
		end
		// stage 2: accumulate, close a row
		if (pend_s2) begin
			macc_q <= msum_c;
			if (pend_row_s2) begin
				res_q[prow_s2] <= sat32(mround_c);
				if (!ppass_s2 && prow_s2 == 2'd3) begin
					vec_q[0] <= res_q[0];
					vec_q[1] <= res_q[1];
					vec_q[2] <= res_q[2];
					vec_q[3] <= sat32(mround_c);
				end
			end
		end
	end

	assign clip_x = res_q[0];
	assign clip_y = res_q[1];
	assign clip_z = res_q[2];
	assign clip_w = res_q[3];
endmodule
`default_nettype wire

// ===== test/lbs_checker.sv =====
module lbs_checker
	import lbs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [271:0] s_tdata,
	input  wire logic [1:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [159:0] m_tdata,
	output int                fail_count,
	output int                pending_count,
	output int                vertex_count
);
	logic [31:0] joint_mem [NumJointsDefault*ElemsPerMatrix];
	logic [31:0] mvp_mem [ElemsPerMatrix];
	logic [159:0] clip_queue [$];

	// round half up by 2^sh, then clamp to signed 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [79:0] v, input int sh);
		logic signed [79:0] r;
		r = (v + (80'sd1 <<< (sh - 1))) >>> sh;
		if (r > 80'sd2147483647) return 32'sh7fffffff;
		if (r < -80'sd2147483648) return 32'sh80000000;
		return r[31:0];
	endfunction

	function automatic logic [159:0] skin_vertex(input logic [271:0] d);
		logic signed [79:0] acc [16];
		logic signed [31:0] skin [16];
		logic signed [31:0] vtx [4];
		logic signed [31:0] skinned [4];
		logic signed [31:0] clip [4];
		logic signed [79:0] row_sum;
		logic [15:0] wt;
		logic [7:0] jn;
		for (int e = 0; e < 16; e++) acc[e] = 0;
		for (int k = 0; k < MaxInfluences; k++) begin
			wt = d[172 + 16*k +: 16];
			jn = d[140 + 8*k +: 8];
			if (wt == 0) continue;  // skipped influence: no read
			for (int e = 0; e < 16; e++)
				acc[e] += $signed({1'b0, wt}) * $signed(joint_mem[jn*16 + e]);
		end
		for (int e = 0; e < 16; e++) skin[e] = round_sat(acc[e], 15);
		vtx[0] = d[75:44];
		vtx[1] = d[107:76];
		vtx[2] = d[139:108];
		vtx[3] = 32'sd65536;
		for (int i = 0; i < 4; i++) begin
			row_sum = 0;
			for (int j = 0; j < 4; j++) row_sum += skin[i*4 + j] * vtx[j];
			skinned[i] = round_sat(row_sum, 16);
		end
		for (int i = 0; i < 4; i++) begin
			row_sum = 0;
			for (int j = 0; j < 4; j++)
				row_sum += $signed(mvp_mem[i*4 + j]) * skinned[j];
			clip[i] = round_sat(row_sum, 16);
		end
		return {d[267:236], clip[3], clip[2], clip[1], clip[0]};
	endfunction

	assign pending_count = clip_queue.size();

	always @(posedge clk) begin
		logic [159:0] want;
		if (!arst_n) begin
			fail_count = 0;
			vertex_count = 0;
		end
		if (arst_n && s_tvalid && s_tready) begin
			case (cmd_t'(s_tuser))
				CMD_JOINT: joint_mem[s_tdata[7:0]*16 + s_tdata[11:8]] = s_tdata[43:12];
				CMD_MVP: mvp_mem[s_tdata[11:8]] = s_tdata[43:12];
				CMD_VERT: clip_queue.push_back(skin_vertex(s_tdata));
				default: ;
			endcase
		end
		if (arst_n && m_tvalid && m_tready) begin
			vertex_count = vertex_count + 1;
			if (clip_queue.size() == 0) begin
				$display("%0t: expected no word, got %h", $time, m_tdata);
				fail_count = fail_count + 1;
			end else begin
				want = clip_queue.pop_front();
				for (int f = 0; f < 5; f++)
					if (want[32*f +: 32] != m_tdata[32*f +: 32]) begin
						$display("%0t: field %0d expected %h got %h", $time, f,
							want[32*f +: 32], m_tdata[32*f +: 32]);
						fail_count = fail_count + 1;
					end
			end
		end
	end
endmodule

// ===== test/tb_top.sv =====
module tb_top;
	import lbs_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [271:0] s_tdata;  // table_index, element_index, element_value, pos, ids, weights, texcoord
	logic [1:0]   s_tuser;  // cmd
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;  // clip_x, clip_y, clip_z, clip_w, texcoord_out
	int           fail_count;
	int           pending_count;
	int           vertex_count;
	int           cycle_count = 0;
	int           item_count;
	// joints that have a full matrix written; vertices only reference these
	logic [7:0]   live_joints [$];

	linear_blend_skinning_transform dut (.*);

	lbs_checker checker_i (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// random gap: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side stalls on its own
	always @(negedge clk) begin
		if (cycle_count < 2000 || cycle_count > 30000) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 99) < 65);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// hold word until accepted; valid drops only for a gap or an idle bus
	task automatic send_word(input cmd_t c, input logic [271:0] d);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tuser <= c;
		s_tdata <= d;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		item_count++;
	endtask

	// drop valid after the last word sent
	task automatic bus_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_elem(input cmd_t c, input logic [7:0] t, input logic [3:0] e,
		input logic [31:0] v);
		logic [271:0] d;
		d = 272'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		d[7:0] = t;
		d[11:8] = e;
		d[43:12] = v;
		send_word(c, d);
	endtask

	function automatic logic [31:0] rand_elem(input int mode);
		case (mode)
			0: return $urandom_range(0, 131072) - 65536;  // near unit range
			1: return $urandom;
			default: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
		endcase
	endfunction

	task automatic load_joint(input logic [7:0] t, input int mode);
		for (int e = 0; e < 16; e++) write_elem(CMD_JOINT, t, e[3:0], rand_elem(mode));
		live_joints.push_back(t);
	endtask

	task automatic load_mvp(input int mode);
		for (int e = 0; e < 16; e++)
			write_elem(CMD_MVP, 8'($urandom), e[3:0], rand_elem(mode));
	endtask

	task automatic send_vertex(input logic [31:0] ids, input logic [63:0] wts,
		input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
		logic [271:0] d;
		d = 272'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		d[75:44] = px;
		d[107:76] = py;
		d[139:108] = pz;
		d[171:140] = ids;
		d[235:172] = wts;
		d[267:236] = $urandom;
		send_vertex_raw(d);
	endtask

	task automatic send_vertex_raw(input logic [271:0] d);
		send_word(CMD_VERT, d);
	endtask

	// random vertex: zero weights for dead slots, live joints elsewhere
	task automatic random_vertex(input int pmode);
		logic [31:0] ids;
		logic [63:0] wts;
		for (int k = 0; k < 4; k++) begin
			ids[8*k +: 8] = 8'($urandom);
			case ($urandom_range(0, 5))
				0: wts[16*k +: 16] = 16'h0;
				1: wts[16*k +: 16] = 16'hffff;
				default: wts[16*k +: 16] = 16'($urandom_range(1, 65535));
			endcase
			if (wts[16*k +: 16] != 0)
				ids[8*k +: 8] = live_joints[$urandom_range(0, live_joints.size() - 1)];
		end
		send_vertex(ids, wts, rand_elem(pmode), rand_elem(pmode), rand_elem(pmode));
	endtask

	// let the block drain before touching its stores
	task automatic settle();
		bus_idle();
		while (pending_count != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	initial begin
		logic [271:0] d;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_NONE;
		item_count = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: near-unit, random and extreme matrices, edge joints
		load_mvp(0);
		load_joint(8'd0, 0);
		load_joint(8'd255, 2);
		load_joint(8'd17, 1);
		send_vertex(32'h00000000, 64'h0000000000008000, 32'h00010000, 32'h0, 32'h0);
		send_vertex(32'h000000ff, 64'h000000000000ffff, 32'h7fffffff, 32'h80000000, 32'h1);
		send_vertex(32'h11ff1100, 64'h0, 32'h12345678, 32'h0, 32'h0);  // nothing used
		send_vertex(32'h11ff0011, 64'hffffffffffffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000);
		send_vertex(32'h00ff1100, 64'h0000800000010000, 32'hffffffff, 32'h0, 32'h7fffffff);
		d = 272'({9{$urandom}});
		send_word(CMD_NONE, d);  // dropped
		write_elem(CMD_JOINT, 8'd0, 4'd15, 32'h7fffffff);
		send_vertex(32'h0, 64'h0000000000000001, 32'h00020000, 32'h00030000, 32'hffff0000);
		settle();
		load_mvp(2);
		send_vertex(32'h11ff0011, 64'h4000400040004000, $urandom, $urandom, $urandom);

		// random phases: rewrite matrices, then stream vertices mixed with element writes and dropped words
		for (int ph = 0; ph < 3; ph++) begin
			int pm;
			pm = ph % 3;
			settle();
			load_mvp(pm);
			for (int j = 0; j < 3; j++) load_joint(8'($urandom), pm);
			for (int n = 0; n < 60; n++) begin
				if ($urandom_range(0, 19) == 0) begin
					d = 272'({9{$urandom}});
					send_word(CMD_NONE, d);
				end else if ($urandom_range(0, 14) == 0)
					write_elem(CMD_MVP, 8'($urandom), 4'($urandom), rand_elem(pm));
				else if ($urandom_range(0, 14) == 0)
					write_elem(CMD_JOINT, live_joints[$urandom_range(0,
						live_joints.size() - 1)], 4'($urandom), rand_elem(pm));
				else
					random_vertex($urandom_range(0, 2));
			end
		end

		bus_idle();
		while (pending_count != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("covered %0d words in, %0d vertices out, %0d joint matrices loaded",
			item_count, vertex_count, live_joints.size());
		$display("weights and positions at extremes, skipped and dropped words included");
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/lbs_pkg.sv
rtl/core/lbs_ctrl.sv
rtl/core/lbs_dp.sv
rtl/core/linear_blend_skinning_transform.sv
test/lbs_checker.sv
test/tb_top.sv
